/* rtl/polynomial_add_sub_mul_assert.svh */
// ----------------------------------------------------------------------------
// Polynomial add/sub/mul assertion macros
// Concurrent checks on the block clock, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_SUB_MUL_ASSERT_SVH
`define POLYNOMIAL_ADD_SUB_MUL_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PASM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("polynomial_add_sub_mul: check failed");
// next-cycle implication
`define PASM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("polynomial_add_sub_mul: check failed");
`else
`define PASM_ASSERT_NOW(lbl, ante, cons)
`define PASM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/pasm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared sizes, operation codes and pipeline tag type.
// ----------------------------------------------------------------------------
package pasm_pkg;

    localparam int MAX_TERMS = 16;
    localparam int OUT_LIMIT = 31;
    localparam int DEG_W     = 5;
    localparam int COEF_W    = 32;
    localparam int OP_W      = 2;
    // load count holds 0 .. MAX_TERMS
    localparam int N_W       = $clog2(MAX_TERMS + 1);
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    // adder tree depth and lane count rounded up to a power of two
    localparam int LVL       = $clog2(MAX_TERMS);
    localparam int LANES     = 1 << LVL;
    // wide enough for 2*MAX_TERMS-1 and OUT_LIMIT
    localparam int CMP_W     = 7;

    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             last;
        logic             drop;
        logic             is_mul;
        t_coef            addsub;
    } t_tag;

endpackage

/* rtl/pasm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_lane
// One multiply lane: registered low word of a coefficient product.
// ----------------------------------------------------------------------------
module pasm_lane import pasm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  logic  i_on,
    input  t_coef i_a,
    input  t_coef i_b,
    output t_coef o_prod
);

    t_coef w_prod;
    t_coef r_prod;

    // low word only: wraps the same for signed and unsigned
    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_on ? w_prod : '0;
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/pasm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_merge
// Registered adder tree over lane products; tag and add/sub result alongside.
// ----------------------------------------------------------------------------
module pasm_merge import pasm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_tag  i_tag,
    input  t_coef i_prod [LANES],
    output logic  o_valid,
    output t_tag  o_tag,
    output t_coef o_coef
);

    // heap order: node j sums nodes 2j and 2j+1, leaves from LANES up
    t_coef w_node [2*LANES];
    t_coef r_node [LANES];
    t_tag  w_tag  [LVL+1];
    t_tag  r_tag  [LVL+1];
    logic  w_valid [LVL+1];
    logic  r_valid [LVL+1];

    always_comb begin
        w_node[0] = '0;
        for (int j = 1; j < 2*LANES; j++) begin
            w_node[j] = (j >= LANES) ? i_prod[j-LANES] : r_node[j];
        end
        for (int l = 0; l <= LVL; l++) begin
            w_tag[l]   = (l == 0) ? i_tag   : r_tag[l];
            w_valid[l] = (l == 0) ? i_valid : r_valid[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 1; j < LANES; j++) begin
                r_node[j] <= w_node[2*j] + w_node[2*j+1];
            end
            for (int l = 1; l <= LVL; l++) begin
                r_tag[l] <= w_tag[l-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= LVL; l++) begin
                r_valid[l] <= 1'b0;
            end
        end else if (i_adv) begin
            for (int l = 1; l <= LVL; l++) begin
                r_valid[l] <= w_valid[l-1];
            end
        end
    end

    assign o_valid = w_valid[LVL];
    assign o_tag   = w_tag[LVL];
    assign o_coef  = w_tag[LVL].is_mul ? w_node[1] : w_tag[LVL].addsub;

endmodule

/* rtl/polynomial_add_sub_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul
// Loads two polynomials term by term, then streams A+B, A-B or A*B.
// ----------------------------------------------------------------------------
// Slave stream: one word per degree from 0 up, coef_a in tdata[31:0], coef_b
// in tdata[63:32]; tlast on the highest term closes the load. Terms beyond
// MAX_TERMS are discarded and flag the run as dropped.
// Config channel: 2-bit operation (0 add, 1 subtract, 2 multiply, 3 add),
// which the user must write only while idle (not enforced); always ready.
// Master stream: one word per result degree, zeros included, tlast on the
// highest degree, tuser set on every word of a run that lost terms.
// Loading accepts one term per cycle. After the last term, results issue one
// per cycle while the receiver keeps up, through a multiply stage and a
// log2(MAX_TERMS)-level adder tree (16 lanes, 4 levels); the loader is freed
// once the last result has issued and a drain state has passed.
// Each multiply term is summed by MAX_TERMS parallel lanes at once.
// Reset empties the load and the pipeline and sets operation to add; stored
// coefficients are not cleared. A stalled receiver freezes the whole
// pipeline; the output register holds its word until taken.
// ----------------------------------------------------------------------------
`include "polynomial_add_sub_mul_assert.svh"

module polynomial_add_sub_mul import pasm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [63:0]     s_axis_tdata,   // coef_a, coef_b
    input  logic            s_axis_tlast,   // last_term
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [39:0]     m_axis_tdata,   // degree, coef, zero pad
    output logic            m_axis_tlast,   // end_of_result
    output logic            m_axis_tuser,   // dropped
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [OP_W-1:0] i_cfg_data      // operation
);

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_LOAD  = 2'd0;
    localparam logic [ST_W-1:0] S_RUN   = 2'd1;
    localparam logic [ST_W-1:0] S_DRAIN = 2'd2;

    logic [ST_W-1:0]  r_state, n_state;
    logic [N_W-1:0]   r_cnt;
    logic             r_ovf;
    logic [OP_W-1:0]  r_op;
    logic [N_W-1:0]   r_n;
    logic [DEG_W-1:0] r_emit;
    logic             r_drop;
    logic [DEG_W-1:0] r_k;

    t_coef            r_store_a [MAX_TERMS];
    t_coef            r_store_b [MAX_TERMS];

    // stage 1: shift line of B aligned to the current degree
    logic             r_v1;
    t_coef            r_s [MAX_TERMS];
    t_coef            r_ak;
    logic [DEG_W-1:0] r_deg1;
    logic             r_last1;

    // stage 2: lane products and add/sub result
    logic             r_v2;
    t_tag             r_tag2;
    t_coef            w_prod [LANES];

    logic             m_valid;
    t_tag             m_tag;
    t_coef            m_coef;

    logic             r_out_valid;
    logic [DEG_W-1:0] r_out_deg;
    t_coef            r_out_coef;
    logic             r_out_last;
    logic             r_out_drop;

    logic             w_adv;
    logic             w_in_acc;
    logic             w_room;
    logic [N_W-1:0]   w_n;
    logic [CMP_W-1:0] w_total;
    logic [DEG_W-1:0] w_emit;
    logic             w_issue;
    logic             w_final;
    logic             w_feed;

    assign w_adv    = !r_out_valid || m_axis_tready;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_room   = r_cnt < N_W'(MAX_TERMS);
    assign w_n      = r_cnt + N_W'(w_room);
    assign w_total  = (r_op == OP_MUL) ? ((CMP_W'(w_n) << 1) - CMP_W'(1)) : CMP_W'(w_n);
    assign w_emit   = (w_total > CMP_W'(OUT_LIMIT)) ? DEG_W'(OUT_LIMIT) : w_total[DEG_W-1:0];
    assign w_issue  = (r_state == S_RUN) && w_adv;
    assign w_final  = r_k == (r_emit - DEG_W'(1));
    assign w_feed   = CMP_W'(r_k) < CMP_W'(r_n);

    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_issue && w_final) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // lanes read store A once more on this advance
                if (w_adv) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_op    <= '0;
            r_k     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_op <= i_cfg_data;
            end
            if (w_in_acc) begin
                if (s_axis_tlast) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    r_k   <= '0;
                end else if (w_room) begin
                    r_cnt <= r_cnt + N_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_issue) begin
                r_k <= r_k + DEG_W'(1);
            end
            if (w_adv) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            r_store_a[r_cnt[IDX_W-1:0]] <= s_axis_tdata[31:0];
            r_store_b[r_cnt[IDX_W-1:0]] <= s_axis_tdata[63:32];
        end
        if (w_in_acc && s_axis_tlast) begin
            r_n    <= w_n;
            r_emit <= w_emit;
            r_drop <= r_ovf || !w_room || (w_total > CMP_W'(OUT_LIMIT));
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_s[i] <= '0;
            end
        end else if (w_issue) begin
            r_s[0]  <= w_feed ? r_store_b[r_k[IDX_W-1:0]] : '0;
            for (int i = 1; i < MAX_TERMS; i++) begin
                r_s[i] <= r_s[i-1];
            end
            r_ak    <= w_feed ? r_store_a[r_k[IDX_W-1:0]] : '0;
            r_deg1  <= r_k;
            r_last1 <= w_final;
        end
        if (w_adv) begin
            r_tag2.degree <= r_deg1;
            r_tag2.last   <= r_last1;
            r_tag2.drop   <= r_drop;
            r_tag2.is_mul <= (r_op == OP_MUL);
            r_tag2.addsub <= (r_op == OP_SUB) ? (r_ak - r_s[0]) : (r_ak + r_s[0]);
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i < MAX_TERMS) begin : g_on
            pasm_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_on   (CMP_W'(i) < CMP_W'(r_n)),
                .i_a    (r_store_a[i]),
                .i_b    (r_s[i]),
                .o_prod (w_prod[i])
            );
        end else begin : g_off
            assign w_prod[i] = '0;
        end
    end

    pasm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v2),
        .i_tag   (r_tag2),
        .i_prod  (w_prod),
        .o_valid (m_valid),
        .o_tag   (m_tag),
        .o_coef  (m_coef)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && m_valid) begin
            r_out_deg  <= m_tag.degree;
            r_out_coef <= m_coef;
            r_out_last <= m_tag.last;
            r_out_drop <= m_tag.drop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_coef, r_out_deg};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

    `PASM_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= N_W'(MAX_TERMS))
    `PASM_ASSERT_NOW(a_k_bound, r_state == S_RUN, r_k < r_emit)
    `PASM_ASSERT_NOW(a_load_empty, r_state == S_LOAD, !r_v1)
    `PASM_ASSERT_NEXT(a_last_starts, w_in_acc && s_axis_tlast, r_state == S_RUN && r_k == '0)

endmodule
